>>> rtl/u8s_pkg.sv
// u8s_pkg: shared types, constants and helpers for the utf8 sanitizer
// used by utf8_sanitizer; no dependencies
`default_nettype none

package u8s_pkg;

	// one entry of a result list: a literal byte or a whole U+FFFD
	typedef struct packed {
		logic       repl;
		logic [7:0] value;
	} tok_t;

	// at most four entries per input byte (four replacements = 12 bytes)
	localparam int unsigned TOK_DEPTH = 4;

	localparam logic [7:0] ASCII_LIMIT = 8'h80;
	localparam logic [7:0] LEAD_MIN    = 8'hC2;
	localparam logic [7:0] LEAD_3B     = 8'hE0;
	localparam logic [7:0] LEAD_4B     = 8'hF0;
	localparam logic [7:0] LEAD_MAX    = 8'hF4;
	localparam logic [7:0] CONT_BASE   = 8'h80;
	localparam logic [7:0] CONT_MAX    = 8'h3F;

	localparam logic [15:0] BOUND_2B = 16'h007F;
	localparam logic [15:0] BOUND_3B = 16'h07FF;
	localparam logic [15:0] BOUND_4B = 16'hFFFF;

	localparam logic [20:0] CP_LIMIT = 21'h110000;
	localparam logic [20:0] SURR_LO  = 21'h00D800;
	localparam logic [20:0] SURR_HI  = 21'h00DFFF;

	localparam logic [7:0] REPL_B0 = 8'hEF;
	localparam logic [7:0] REPL_B1 = 8'hBF;
	localparam logic [7:0] REPL_B2 = 8'hBD;

	// position of the final byte inside a replacement
	localparam logic [1:0] REPL_LAST = 2'd2;

	// byte of U+FFFD at a given position
	function automatic logic [7:0] repl_byte(input logic [1:0] pos);
		logic [7:0] r;
		case (pos)
			2'd0:    r = REPL_B0;
			2'd1:    r = REPL_B1;
			default: r = REPL_B2;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/utf8_sanitizer.sv
// utf8_sanitizer: streaming utf-8 validator with U+FFFD replacement
// depends on u8s_pkg (token type, byte constants, replacement bytes)
`default_nettype none

// A byte string enters one byte per transaction, string_end set on its last
// byte. Valid utf-8 sequences leave unchanged; each byte that does not start
// a valid sequence leaves as EF BF BD with is_replacement set. Lead and
// continuation bytes are held until their sequence completes or fails, so an
// input byte may cause no output at all or up to twelve output bytes. The
// input byte is decoded combinationally into a list of up to four entries
// (literal byte or replacement) held in a result register; a serializer then
// emits that list at one output byte per cycle while out_ready is high, and
// holds the input side until the list is done. A new input transaction is
// taken in the same cycle as the last output byte of the previous list, so
// plain ASCII text flows at one byte per cycle while out_ready is high.
// run_last marks the last output of one input byte, string_last the last
// output of a string_end byte. No clearing pass after reset.
module utf8_sanitizer (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       string_end,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            is_replacement,
	output logic            run_last,
	output logic            string_last
);

	// decoder state: bytes held for an open sequence
	logic [7:0]  pend_q [3];
	logic [1:0]  pend_cnt_q;     // bytes held
	logic [1:0]  need_q;         // continuation bytes still expected
	logic [20:0] part_q;         // code point bits gathered so far
	logic [15:0] bound_q;        // largest overlong value for this lead

	// result register and serializer position
	u8s_pkg::tok_t desc_q [u8s_pkg::TOK_DEPTH];
	logic          desc_valid_q;
	logic [1:0]    desc_last_q;  // index of the final entry
	logic          desc_end_q;   // list belongs to a string_end byte
	logic [1:0]    tok_idx_q;
	logic [1:0]    sub_q;        // byte position inside a replacement

	// next-state and list built from the current input byte
	logic [7:0]    nx_pend [3];
	logic [1:0]    nx_cnt;
	logic [1:0]    nx_need;
	logic [20:0]   nx_part;
	logic [15:0]   nx_bound;
	u8s_pkg::tok_t tok [u8s_pkg::TOK_DEPTH];
	logic [2:0]    tok_n;

	logic in_fire;
	logic out_fire;
	logic desc_done;

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	// decode one input byte against the held sequence
	always_comb begin
		logic [7:0]  c;
		logic [20:0] u;
		logic        ok;
		logic        fresh;
		logic [1:0]  need_dec;

		c        = in_byte - u8s_pkg::CONT_BASE;
		u        = {part_q[14:0], c[5:0]};
		need_dec = need_q - 2'd1;
		ok       = ({5'd0, bound_q} < u) && (u < u8s_pkg::CP_LIMIT) &&
		           !((u >= u8s_pkg::SURR_LO) && (u <= u8s_pkg::SURR_HI));
		fresh    = 1'b0;

		nx_pend  = pend_q;
		nx_cnt   = pend_cnt_q;
		nx_need  = need_q;
		nx_part  = part_q;
		nx_bound = bound_q;
		tok_n    = 3'd0;
		for (int i = 0; i < u8s_pkg::TOK_DEPTH; i++) begin
			tok[i] = '{repl: 1'b0, value: 8'h00};
		end

		if (pend_cnt_q == 2'd0) begin
			fresh = 1'b1;
		end else if (c > u8s_pkg::CONT_MAX) begin
			// not a continuation: held bytes fail, byte is rescanned
			for (int i = 0; i < 3; i++) begin
				if (i < int'(pend_cnt_q)) begin
					tok[tok_n[1:0]] = '{repl: 1'b1, value: 8'h00};
					tok_n = tok_n + 3'd1;
				end
			end
			nx_cnt   = 2'd0;
			nx_need  = 2'd0;
			nx_part  = '0;
			nx_bound = '0;
			fresh    = 1'b1;
		end else if (need_dec == 2'd0) begin
			// sequence complete: pass it through or fail every byte
			for (int i = 0; i < 3; i++) begin
				if (i < int'(pend_cnt_q)) begin
					tok[tok_n[1:0]] = '{repl: !ok, value: pend_q[i]};
					tok_n = tok_n + 3'd1;
				end
			end
			tok[tok_n[1:0]] = '{repl: !ok, value: in_byte};
			tok_n    = tok_n + 3'd1;
			nx_cnt   = 2'd0;
			nx_need  = 2'd0;
			nx_part  = '0;
			nx_bound = '0;
		end else if (pend_cnt_q != 2'd3) begin
			nx_pend[pend_cnt_q] = in_byte;
			nx_cnt  = pend_cnt_q + 2'd1;
			nx_need = need_dec;
			nx_part = u;
		end else begin
			// held list full with bytes still expected
			for (int i = 0; i < 3; i++) begin
				tok[tok_n[1:0]] = '{repl: 1'b1, value: 8'h00};
				tok_n = tok_n + 3'd1;
			end
			tok[tok_n[1:0]] = '{repl: 1'b1, value: 8'h00};
			tok_n    = tok_n + 3'd1;
			nx_cnt   = 2'd0;
			nx_need  = 2'd0;
			nx_part  = '0;
			nx_bound = '0;
		end

		if (fresh) begin
			if (in_byte < u8s_pkg::ASCII_LIMIT) begin
				tok[tok_n[1:0]] = '{repl: 1'b0, value: in_byte};
				tok_n = tok_n + 3'd1;
			end else if (in_byte >= u8s_pkg::LEAD_MIN && in_byte <= u8s_pkg::LEAD_MAX) begin
				nx_pend[0] = in_byte;
				nx_cnt     = 2'd1;
				if (in_byte >= u8s_pkg::LEAD_4B) begin
					nx_part  = {18'd0, in_byte[2:0]};
					nx_bound = u8s_pkg::BOUND_4B;
					nx_need  = 2'd3;
				end else if (in_byte >= u8s_pkg::LEAD_3B) begin
					nx_part  = {17'd0, in_byte[3:0]};
					nx_bound = u8s_pkg::BOUND_3B;
					nx_need  = 2'd2;
				end else begin
					nx_part  = {16'd0, in_byte[4:0]};
					nx_bound = u8s_pkg::BOUND_2B;
					nx_need  = 2'd1;
				end
			end else begin
				tok[tok_n[1:0]] = '{repl: 1'b1, value: 8'h00};
				tok_n = tok_n + 3'd1;
			end
		end

		// end of string: whatever is still held is truncated
		if (string_end) begin
			for (int i = 0; i < 3; i++) begin
				if (i < int'(nx_cnt)) begin
					tok[tok_n[1:0]] = '{repl: 1'b1, value: 8'h00};
					tok_n = tok_n + 3'd1;
				end
			end
			nx_cnt   = 2'd0;
			nx_need  = 2'd0;
			nx_part  = '0;
			nx_bound = '0;
		end
	end

	// serializer view of the current entry
	u8s_pkg::tok_t cur;
	logic          tok_done;

	assign cur       = desc_q[tok_idx_q];
	assign tok_done  = !cur.repl || (sub_q == u8s_pkg::REPL_LAST);
	assign desc_done = tok_done && (tok_idx_q == desc_last_q);

	// take the next transaction when the list is empty or leaves this cycle
	assign in_ready = !desc_valid_q || (out_ready && desc_done);

	assign out_valid      = desc_valid_q;
	assign out_byte       = cur.repl ? u8s_pkg::repl_byte(sub_q) : cur.value;
	assign is_replacement = cur.repl;
	assign run_last       = desc_done;
	assign string_last    = desc_done && desc_end_q;

	// decoder control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_cnt_q <= 2'd0;
			need_q     <= 2'd0;
			part_q     <= '0;
			bound_q    <= '0;
		end else if (in_fire) begin
			pend_cnt_q <= nx_cnt;
			need_q     <= nx_need;
			part_q     <= nx_part;
			bound_q    <= nx_bound;
		end
	end

	// held bytes, only read below the held count
	always_ff @(posedge clk) begin
		if (in_fire) begin
			pend_q <= nx_pend;
		end
	end

	// result register and serializer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_valid_q <= 1'b0;
			tok_idx_q    <= 2'd0;
			sub_q        <= 2'd0;
		end else if (in_fire && tok_n != 3'd0) begin
			desc_valid_q <= 1'b1;
			tok_idx_q    <= 2'd0;
			sub_q        <= 2'd0;
		end else if (out_fire) begin
			if (desc_done) begin
				desc_valid_q <= 1'b0;
				tok_idx_q    <= 2'd0;
				sub_q        <= 2'd0;
			end else if (tok_done) begin
				tok_idx_q <= tok_idx_q + 2'd1;
				sub_q     <= 2'd0;
			end else begin
				sub_q <= sub_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && tok_n != 3'd0) begin
			desc_q      <= tok;
			desc_last_q <= 2'(tok_n - 3'd1);
			desc_end_q  <= string_end;
		end
	end

	// a string_end transaction leaves nothing held
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && string_end) |=> (pend_cnt_q == 2'd0))
		else $error("bytes still held after end of string");

	// held count and expected count are empty together
	assert property (@(posedge clk) disable iff (!arst_n)
		((pend_cnt_q == 2'd0) == (need_q == 2'd0)))
		else $error("held and expected byte counts disagree");

	// a result list only empties through an output transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(desc_valid_q) |-> $past(out_valid && out_ready && run_last))
		else $error("result list dropped without being sent");

	// a literal byte is never emitted from the middle of a replacement
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !is_replacement) |-> (sub_q == 2'd0))
		else $error("serializer position off on a literal byte");

endmodule

`default_nettype wire
